@@ hdl/sem_pkg.sv @@
package sem_pkg;

  localparam int CFG_W_BITS = 12;
  localparam int CFG_H_BITS = 16;
  localparam int CX_BITS    = 11;
  localparam int CY_BITS    = 16;
  localparam int SQ_W       = 22;
  localparam int SQ_STEPS   = 11;

  localparam logic [CFG_W_BITS-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_H_BITS-1:0] HEIGHT_RESET = 16'd480;
  localparam logic [CFG_W_BITS-1:0] WIDTH_MIN    = 12'd3;
  localparam logic [CFG_H_BITS-1:0] HEIGHT_MIN   = 16'd3;
  localparam logic [SQ_W-1:0]       SQ_TOP_PROBE = 22'h100000;
  localparam logic [SQ_W-1:0]       PIX_MAX      = 22'd255;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } in_req_t;

  typedef struct packed {
    logic [7:0]         edge_value;
    logic [CX_BITS-1:0] center_x;
    logic [CY_BITS-1:0] center_y;
    logic               last;
  } out_req_t;

  typedef struct packed {
    cfg_reg_t    index;
    logic [15:0] wdata;
  } cfg_req_t;

  typedef logic signed [10:0] grad_t;

  // one step of the digit-by-digit root, plus the item's position
  typedef struct packed {
    logic               v;
    logic [SQ_W-1:0]    n;
    logic [SQ_W-1:0]    r;
    logic [SQ_W-1:0]    probe;
    logic [CX_BITS-1:0] cx;
    logic [CY_BITS-1:0] cy;
    logic               last;
  } root_t;

endpackage

@@ hdl/sem_stream_if.sv @@
interface sem_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/sobel_edge_magnitude.sv @@
// Streaming 3x3 Sobel edge detector. Pixels enter in raster order, one per clock while the
// result side keeps up; the whole pipeline advances together and holds when a finished result
// is not taken. Accepting pixel (x+1, y+1) yields the result for interior pixel (x, y) via the
// row-store read, gradient, squaring, 11 root-digit cells and the output register. The result
// is 255 minus the rounded-up gradient magnitude, clamped at 0; border pixels give no result.
// The row store holds MAX_WIDTH entries of two pixels each and is not cleared; the counters
// and window are cleared by reset. The user writes width and height through the configuration
// channel (index 0 width, index 1 height) only while the block is idle; it is not enforced.
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH = 2048
) (
  input logic           clk,
  input logic           rst_n,
  sem_stream_if.sink    in_chan,
  sem_stream_if.source  out_chan,
  sem_stream_if.sink    cfg_chan
);
  import sem_pkg::*;

  logic [CFG_W_BITS-1:0] width_r;
  logic [CFG_H_BITS-1:0] height_r;
  logic                  en;
  root_t                 chain [SQ_STEPS+1];
  logic                  out_valid_r;
  out_req_t              out_data_r;
  logic [SQ_W-1:0]       mag;

  assign en             = !out_valid_r || out_chan.ready;
  assign in_chan.ready  = en;
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.data.index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_chan.data.wdata[CFG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_chan.data.wdata;
      endcase
    end
  end

  sem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_chan.valid),
    .in_data    (in_chan.data),
    .width_cfg  (width_r),
    .height_cfg (height_r),
    .root_out   (chain[0])
  );

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_cell
    sem_root_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .cell_in  (chain[i]),
      .cell_out (chain[i+1])
    );
  end

  // round up when a remainder is left
  assign mag = chain[SQ_STEPS].r + SQ_W'(chain[SQ_STEPS].n != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain[SQ_STEPS].v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.edge_value <= (mag > PIX_MAX) ? 8'd0 : 8'(PIX_MAX - mag);
      out_data_r.center_x   <= chain[SQ_STEPS].cx;
      out_data_r.center_y   <= chain[SQ_STEPS].cy;
      out_data_r.last       <= chain[SQ_STEPS].last;
    end
  end

endmodule

@@ hdl/sem_front.sv @@
module sem_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  sem_pkg::in_req_t                in_data,
  input  logic [sem_pkg::CFG_W_BITS-1:0]  width_cfg,
  input  logic [sem_pkg::CFG_H_BITS-1:0]  height_cfg,
  output sem_pkg::root_t                  root_out
);
  import sem_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (CW > CFG_W_BITS) ? CW : CFG_W_BITS;
  localparam int XE = (XW > CX_BITS) ? XW : CX_BITS;

  logic [EW-1:0]      w_eff, c0, xn;
  logic [15:0]        h_eff, r0, r1;
  logic [XW-1:0]      x_in, col_r, col_nxt;
  logic [15:0]        row_r, row_nxt;
  logic               accept, fwd_hit, emit, last_in;
  logic [CX_BITS-1:0] cx_in;
  logic [CY_BITS-1:0] cy_in;

  logic [15:0]        mem [MAX_WIDTH];
  logic [15:0]        rd_r, byp_r, row_pair;
  logic               fwd_r;
  logic               s0_v_r, s0_emit_r, s0_last_r;
  logic [7:0]         s0_pix_r;
  logic [XW-1:0]      s0_x_r;
  logic [CX_BITS-1:0] s0_cx_r;
  logic [CY_BITS-1:0] s0_cy_r;
  logic [7:0]         s0_top, s0_mid;
  logic [7:0]         win_r [6];
  grad_t              gx, gy, s1_gx_r, s1_gy_r;
  logic               s1_v_r, s1_last_r;
  logic [CX_BITS-1:0] s1_cx_r;
  logic [CY_BITS-1:0] s1_cy_r;
  logic signed [SQ_W-1:0] gx2, gy2;
  root_t              root_r;

  // frame position of the incoming pixel
  always_comb begin
    if (width_cfg < WIDTH_MIN) begin
      w_eff = EW'(WIDTH_MIN);
    end else if (EW'(width_cfg) > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(width_cfg);
    end
    h_eff = (height_cfg < HEIGHT_MIN) ? HEIGHT_MIN : height_cfg;

    c0 = in_data.frame_start ? '0 : EW'(col_r);
    r0 = in_data.frame_start ? '0 : row_r;
    r1 = r0;
    if (c0 >= w_eff) begin
      c0 = '0;
      r1 = r0 + 16'd1;
    end
    if (r1 >= h_eff) begin
      r1 = '0;
    end
    x_in = XW'(c0);
    xn = EW'(x_in) + EW'(1);
    if (xn >= w_eff) begin
      col_nxt = '0;
      row_nxt = r1 + 16'd1;
      if (row_nxt >= h_eff) begin
        row_nxt = '0;
      end
    end else begin
      col_nxt = XW'(xn);
      row_nxt = r1;
    end
    emit    = (EW'(x_in) >= EW'(2)) && (r1 >= 16'd2);
    last_in = (xn == w_eff) && ((r1 + 16'd1) == h_eff);
    cx_in   = CX_BITS'(XE'(x_in) - XE'(1));
    cy_in   = r1 - 16'd1;
  end

  assign accept  = en && in_valid;
  assign fwd_hit = s0_v_r && (s0_x_r == x_in);

  assign row_pair = fwd_r ? byp_r : rd_r;
  assign s0_top   = row_pair[15:8];
  assign s0_mid   = row_pair[7:0];

  // window columns x-2 and x-1 in win_r, column x from the row store and the incoming pixel
  always_comb begin
    gx = (grad_t'(win_r[0]) - grad_t'(s0_top))
       + ((grad_t'(win_r[1]) - grad_t'(s0_mid)) <<< 1)
       + (grad_t'(win_r[2]) - grad_t'(s0_pix_r));
    gy = (grad_t'(win_r[0]) + (grad_t'(win_r[3]) <<< 1) + grad_t'(s0_top))
       - (grad_t'(win_r[2]) + (grad_t'(win_r[5]) <<< 1) + grad_t'(s0_pix_r));
  end

  assign gx2 = SQ_W'(s1_gx_r) * SQ_W'(s1_gx_r);
  assign gy2 = SQ_W'(s1_gy_r) * SQ_W'(s1_gy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      s0_v_r   <= 1'b0;
      fwd_r    <= 1'b0;
      s1_v_r   <= 1'b0;
      root_r.v <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (en) begin
      s0_v_r   <= in_valid;
      fwd_r    <= in_valid && fwd_hit;
      s1_v_r   <= s0_v_r && s0_emit_r;
      root_r.v <= s1_v_r;
      root_r.n     <= $unsigned(gx2) + $unsigned(gy2);
      root_r.r     <= '0;
      root_r.probe <= SQ_TOP_PROBE;
      root_r.cx    <= s1_cx_r;
      root_r.cy    <= s1_cy_r;
      root_r.last  <= s1_last_r;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (s0_v_r) begin
        win_r[0] <= win_r[3];
        win_r[1] <= win_r[4];
        win_r[2] <= win_r[5];
        win_r[3] <= s0_top;
        win_r[4] <= s0_mid;
        win_r[5] <= s0_pix_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_r      <= mem[x_in];
      byp_r     <= {s0_mid, s0_pix_r};
      s0_pix_r  <= in_data.pixel;
      s0_x_r    <= x_in;
      s0_emit_r <= emit;
      s0_last_r <= last_in;
      s0_cx_r   <= cx_in;
      s0_cy_r   <= cy_in;
      if (s0_v_r) begin
        mem[s0_x_r] <= {s0_mid, s0_pix_r};
      end
      s1_gx_r   <= gx;
      s1_gy_r   <= gy;
      s1_cx_r   <= s0_cx_r;
      s1_cy_r   <= s0_cy_r;
      s1_last_r <= s0_last_r;
    end
  end

  assign root_out = root_r;

endmodule

@@ hdl/sem_root_cell.sv @@
module sem_root_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  sem_pkg::root_t cell_in,
  output sem_pkg::root_t cell_out
);
  import sem_pkg::*;

  logic [SQ_W-1:0] trial;
  root_t           cell_r;

  assign trial = cell_in.r + cell_in.probe;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.v <= 1'b0;
    end else if (en) begin
      cell_r.v <= cell_in.v;
      if (cell_in.n >= trial) begin
        cell_r.n <= cell_in.n - trial;
        cell_r.r <= (cell_in.r >> 1) + cell_in.probe;
      end else begin
        cell_r.n <= cell_in.n;
        cell_r.r <= cell_in.r >> 1;
      end
      cell_r.probe <= cell_in.probe >> 2;
      cell_r.cx    <= cell_in.cx;
      cell_r.cy    <= cell_in.cy;
      cell_r.last  <= cell_in.last;
    end
  end

  assign cell_out = cell_r;

endmodule
